FILE: hdl/aat_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aat_pkg
// Shared types, register codes and helpers for the box affine transform.
// ---------------------------------------------------------------------------
package aat_pkg;

  localparam int unsigned CoordW = 32;  // Q16.16 coordinate
  localparam int unsigned CoefW  = 16;  // Q4.12 coefficient
  localparam int unsigned RowW   = 3 * CoefW;
  localparam int unsigned WideW  = CoordW + 1;  // exact sum / difference
  localparam int unsigned AccW   = 52;  // exact centre / half-size sums
  localparam int unsigned FracSh = 13;  // Q4.12 * (2 * Q16.16) -> Q16.16
  localparam int unsigned FlW    = AccW - FracSh;

  localparam logic [RowW-1:0] Row0Reset = 48'h0000_0000_1000;
  localparam logic [RowW-1:0] Row1Reset = 48'h0000_1000_0000;
  localparam logic [RowW-1:0] Row2Reset = 48'h1000_0000_0000;

  typedef enum logic [2:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_TRANS_X = 3'd3,
    REG_TRANS_Y = 3'd4,
    REG_TRANS_Z = 3'd5
  } cfg_reg_e;

  typedef logic signed [WideW-1:0] wide_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_z;
  } box_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_min_x;
    logic signed [CoordW-1:0] out_min_y;
    logic signed [CoordW-1:0] out_min_z;
    logic signed [CoordW-1:0] out_max_x;
    logic signed [CoordW-1:0] out_max_y;
    logic signed [CoordW-1:0] out_max_z;
    logic                     clipped;
    logic                     unordered_box;
  } box_out_t;

  // per-stage load enables handed to each axis datapath
  typedef struct packed {
    logic mul;
    logic sum;
    logic fin;
  } stage_en_t;

  typedef struct packed {
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
    logic                     clip;
  } axis_res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] value;
    logic                     clip;
  } sat_t;

  // clamp a floored value to 32 bits
  function automatic sat_t sat32(input logic signed [FlW-1:0] v);
    sat_t r;
    r.clip  = (v[FlW-1:CoordW-1] != {(FlW-CoordW+1){v[FlW-1]}});
    r.value = v[CoordW-1:0];
    if (r.clip) begin
      r.value = v[FlW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hdl/aabb_affine_transform.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_affine_transform
// Encloses an axis-aligned 3D box after an affine transform.
// ---------------------------------------------------------------------------
// Usage:
//   Box channel: a transaction is taken on a clock edge with start_i high and
//   busy_o low; box_i carries min and max corners in Q16.16.
//   Result channel: res_o is valid for exactly one cycle while done_o is high.
//   There is no backpressure, so the sink must take every result.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Write only while no box is in flight.
// Timing:
//   done_o rises with the result once a box has passed all four register
//   stages (sum/difference, 18 multipliers, exact adds, floor + clamp). One
//   box per cycle is sustained once busy_o is low: none of these stages
//   ever holds its data.
// Reset:
//   rst_ni clears all valid bits and loads the identity matrix with zero
//   translation. busy_o is high for the first cycle after reset only.
// ---------------------------------------------------------------------------
module aabb_affine_transform (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // box channel
  input  logic                     start_i,
  output logic                     busy_o,
  input  aat_pkg::box_in_t         box_i,
  // result channel
  output logic                     done_o,
  output aat_pkg::box_out_t        res_o,
  // config channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [2:0]               cfg_index_i,
  input  logic [aat_pkg::RowW-1:0] cfg_data_i
);
  import aat_pkg::*;

  // config registers
  logic [RowW-1:0]          row_q [3];
  logic signed [CoordW-1:0] trans_q [3];

  // pipeline control
  logic       busy_q;
  logic       accept;
  logic       v1_q, v2_q, v3_q, done_q;
  logic       un1_q, un2_q, un3_q, un4_q;
  stage_en_t  en;

  // stage 1 data
  logic signed [CoordW-1:0] mn [3];
  logic signed [CoordW-1:0] mx [3];
  wide_t                    s_d [3];
  wide_t                    d_d [3];
  wide_t                    s_q [3];
  wide_t                    d_q [3];
  logic                     un_d;

  axis_res_t ax [3];

  assign accept      = start_i & ~busy_q;
  assign busy_o      = busy_q;
  assign cfg_ready_o = 1'b1;

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= Row0Reset;
      row_q[1]   <= Row1Reset;
      row_q[2]   <= Row2Reset;
      trans_q[0] <= '0;
      trans_q[1] <= '0;
      trans_q[2] <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ROW0:    row_q[0]   <= cfg_data_i;
        REG_ROW1:    row_q[1]   <= cfg_data_i;
        REG_ROW2:    row_q[2]   <= cfg_data_i;
        REG_TRANS_X: trans_q[0] <= cfg_data_i[CoordW-1:0];
        REG_TRANS_Y: trans_q[1] <= cfg_data_i[CoordW-1:0];
        REG_TRANS_Z: trans_q[2] <= cfg_data_i[CoordW-1:0];
        default:     ;
      endcase
    end
  end

  // stage 1: exact corner sum (twice the centre) and difference (twice the half-size)
  always_comb begin
    mn[0] = box_i.min_x;
    mn[1] = box_i.min_y;
    mn[2] = box_i.min_z;
    mx[0] = box_i.max_x;
    mx[1] = box_i.max_y;
    mx[2] = box_i.max_z;
    un_d  = 1'b0;
    for (int j = 0; j < 3; j++) begin
      s_d[j] = WideW'(mx[j]) + WideW'(mn[j]);
      d_d[j] = WideW'(mx[j]) - WideW'(mn[j]);
      un_d   = un_d | (mn[j] > mx[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q   <= s_d;
      d_q   <= d_d;
      un1_q <= un_d;
    end
    if (v1_q) un2_q <= un1_q;
    if (v2_q) un3_q <= un2_q;
    if (v3_q) un4_q <= un3_q;
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  assign en = '{mul: v1_q, sum: v2_q, fin: v3_q};

  for (genvar i = 0; i < 3; i++) begin : g_axis
    aat_axis u_axis (
      .clk_i   (clk_i),
      .en_i    (en),
      .row_i   (row_q[i]),
      .trans_i (trans_q[i]),
      .s_i     (s_q),
      .d_i     (d_q),
      .res_o   (ax[i])
    );
  end

  assign done_o              = done_q;
  assign res_o.out_min_x     = ax[0].lo;
  assign res_o.out_min_y     = ax[1].lo;
  assign res_o.out_min_z     = ax[2].lo;
  assign res_o.out_max_x     = ax[0].hi;
  assign res_o.out_max_y     = ax[1].hi;
  assign res_o.out_max_z     = ax[2].hi;
  assign res_o.clipped       = ax[0].clip | ax[1].clip | ax[2].clip;
  assign res_o.unordered_box = un4_q;

  // every accepted box comes out as a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("accepted box did not complete in four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without an accepted box");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.clipped) |->
      (res_o.out_min_x == 32'sh7fffffff || res_o.out_min_x == 32'sh80000000 ||
       res_o.out_min_y == 32'sh7fffffff || res_o.out_min_y == 32'sh80000000 ||
       res_o.out_min_z == 32'sh7fffffff || res_o.out_min_z == 32'sh80000000 ||
       res_o.out_max_x == 32'sh7fffffff || res_o.out_max_x == 32'sh80000000 ||
       res_o.out_max_y == 32'sh7fffffff || res_o.out_max_y == 32'sh80000000 ||
       res_o.out_max_z == 32'sh7fffffff || res_o.out_max_z == 32'sh80000000))
    else $error("clip flagged without a clamped coordinate");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.unordered_box) |->
      (res_o.out_min_x <= res_o.out_max_x && res_o.out_min_y <= res_o.out_max_y &&
       res_o.out_min_z <= res_o.out_max_z))
    else $error("ordered box produced an inverted result");

endmodule

FILE: hdl/aat_axis.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aat_axis
// One output axis: products, exact sums, floor shift and saturation.
// ---------------------------------------------------------------------------
module aat_axis (
  input  logic                       clk_i,
  input  aat_pkg::stage_en_t         en_i,
  input  logic [aat_pkg::RowW-1:0]   row_i,
  input  logic signed [31:0]         trans_i,
  input  aat_pkg::wide_t             s_i [3],
  input  aat_pkg::wide_t             d_i [3],
  output aat_pkg::axis_res_t         res_o
);
  import aat_pkg::*;

  logic signed [48:0]     pc_d [3];
  logic signed [48:0]     pc_q [3];
  logic signed [50:0]     ph_d [3];
  logic signed [50:0]     ph_q [3];
  logic signed [AccW-1:0] c_d, c_q, h_d, h_q;
  logic signed [AccW-1:0] lo_sum, hi_sum;
  axis_res_t              res_d, res_q;
  sat_t                   sat_lo, sat_hi;

  // stage: six products per axis, three linear and three with absolute coefficients
  always_comb begin
    logic signed [CoefW-1:0] l;
    logic signed [CoefW:0]   lx;
    logic [CoefW:0]          al;
    for (int j = 0; j < 3; j++) begin
      l       = row_i[CoefW*j +: CoefW];
      lx      = {l[CoefW-1], l};
      al      = lx[CoefW] ? 17'(-lx) : 17'(lx);  // -8.0 gives +8.0
      pc_d[j] = l * s_i[j];
      ph_d[j] = $signed({1'b0, al}) * d_i[j];
    end
  end

  // stage: centre and half-size sums, kept exact
  assign c_d = AccW'(pc_q[0]) + AccW'(pc_q[1]) + AccW'(pc_q[2])
             + $signed({{(AccW-CoordW-FracSh){trans_i[31]}}, trans_i, {FracSh{1'b0}}});
  assign h_d = AccW'(ph_q[0]) + AccW'(ph_q[1]) + AccW'(ph_q[2]);

  // stage: corners, floor by arithmetic shift, clamp
  assign lo_sum = c_q - h_q;
  assign hi_sum = c_q + h_q;
  assign sat_lo = sat32(lo_sum[AccW-1:FracSh]);
  assign sat_hi = sat32(hi_sum[AccW-1:FracSh]);
  assign res_d  = '{lo: sat_lo.value, hi: sat_hi.value, clip: sat_lo.clip | sat_hi.clip};

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      pc_q <= pc_d;
      ph_q <= ph_d;
    end
    if (en_i.sum) begin
      c_q <= c_d;
      h_q <= h_d;
    end
    if (en_i.fin) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

FILE: verif/aabb_affine_transform_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_affine_transform_test
// Self-checking bench for the box affine transform. A behavioral predictor
// works out the enclosing box, the clip flag and the unordered flag of every
// accepted box; each result strobe is compared field by field with the
// oldest prediction. Directed boxes cover reset state, coefficient and
// translation extremes, saturation, unordered boxes and register decode;
// random streams then run under several transforms and sender idle rates.
// ---------------------------------------------------------------------------
module aabb_affine_transform_test;

  import aat_pkg::*;

  localparam int unsigned ClkPeriod = 8;
  localparam int unsigned FracShift = 13;  // Q4.12 times twice Q16.16
  localparam int unsigned PipeDepth = 4;   // accept edge to done_o
  localparam int unsigned PrintCap  = 40;

  // spare register indexes, writes to them must change nothing
  localparam logic [2:0] IdxSpare0 = 3'd6;
  localparam logic [2:0] IdxSpare1 = 3'd7;

  // transform as the registers hold it: three packed rows, three offsets
  typedef struct packed {
    logic [2:0][RowW-1:0]   row;
    logic [2:0][CoordW-1:0] offset;
  } xform_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  box_in_t             box_i;
  logic                done_o;
  box_out_t            res_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [2:0]          cfg_index_i;
  logic [RowW-1:0]     cfg_data_i;

  xform_t   cur_xform;   // shadow of the block's registers
  box_out_t boxes_due[$];
  int       mismatch_count;

  aabb_affine_transform i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .box_i       (box_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // {saturated, value}: clamp an exact floored sum to a signed 32-bit value
  function automatic logic [32:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end
    if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // Centre/half-size form, kept exact: centre*2 = max+min, half*2 = max-min,
  // so the Q4.12 product needs a single floor shift of 13 at the very end.
  function automatic box_out_t transform_box(box_in_t b);
    logic [2:0][31:0] lo_c;
    logic [2:0][31:0] hi_c;
    logic [2:0][31:0] out_lo;
    logic [2:0][31:0] out_hi;
    logic [32:0]      sat;
    longint           sum_v[3];
    longint           dif_v[3];
    longint           cen;
    longint           half;
    longint           lin;
    longint           mag;
    logic signed [15:0] k;
    bit               clip;
    bit               unord;
    box_out_t         r;
    int               i;
    int               j;
    lo_c  = {b.min_z, b.min_y, b.min_x};
    hi_c  = {b.max_z, b.max_y, b.max_x};
    clip  = 1'b0;
    unord = 1'b0;
    for (j = 0; j < 3; j++) begin
      if ($signed(lo_c[j]) > $signed(hi_c[j])) unord = 1'b1;
      sum_v[j] = longint'($signed(hi_c[j])) + longint'($signed(lo_c[j]));
      dif_v[j] = longint'($signed(hi_c[j])) - longint'($signed(lo_c[j]));
    end
    for (i = 0; i < 3; i++) begin
      cen  = longint'($signed(cur_xform.offset[i])) * (longint'(1) << FracShift);
      half = 0;
      for (j = 0; j < 3; j++) begin
        k    = cur_xform.row[i][16*j +: 16];
        lin  = longint'(k);
        mag  = (lin < 0) ? -lin : lin;  // -8.0 becomes +8.0 here
        cen  += lin * sum_v[j];
        half += mag * dif_v[j];
      end
      sat       = clamp32((cen - half) >>> FracShift);
      out_lo[i] = sat[31:0];
      clip     |= sat[32];
      sat       = clamp32((cen + half) >>> FracShift);
      out_hi[i] = sat[31:0];
      clip     |= sat[32];
    end
    r.out_min_x     = out_lo[0];
    r.out_min_y     = out_lo[1];
    r.out_min_z     = out_lo[2];
    r.out_max_x     = out_hi[0];
    r.out_max_y     = out_hi[1];
    r.out_max_z     = out_hi[2];
    r.clipped       = clip;
    r.unordered_box = unord;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Reporting and result checking
  // -------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintCap) $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Results cannot be held off, so every strobe is a transaction.
  always @(posedge clk_i) begin
    box_out_t want;
    if (rst_ni === 1'b1) begin
      if (done_o === 1'b1) begin
        if (boxes_due.size() == 0) begin
          report_mismatch("result with no box outstanding");
        end else begin
          want = boxes_due.pop_front();
          check_field("out_min_x", res_o.out_min_x, want.out_min_x);
          check_field("out_min_y", res_o.out_min_y, want.out_min_y);
          check_field("out_min_z", res_o.out_min_z, want.out_min_z);
          check_field("out_max_x", res_o.out_max_x, want.out_max_x);
          check_field("out_max_y", res_o.out_max_y, want.out_max_y);
          check_field("out_max_z", res_o.out_max_z, want.out_max_z);
          check_field("clipped", 32'(res_o.clipped), 32'(want.clipped));
          check_field("unordered_box", 32'(res_o.unordered_box),
                      32'(want.unordered_box));
        end
      end else if (done_o !== 1'b0) begin
        report_mismatch("done_o unknown");
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers. All tasks are entered and left right after a rising edge.
  // -------------------------------------------------------------------------

  // One box transaction; the prediction is taken at the accepting edge.
  task automatic send_box(input box_in_t b, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    box_i   <= b;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    boxes_due.push_back(transform_box(b));
  endtask

  // Leaves cfg_valid_i high so back-to-back writes keep it steady.
  task automatic write_reg(input logic [2:0] idx, input logic [RowW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_ROW0, REG_ROW1, REG_ROW2:          cur_xform.row[idx] = data;
      REG_TRANS_X, REG_TRANS_Y, REG_TRANS_Z: cur_xform.offset[idx - REG_TRANS_X] = data[31:0];
      default: ;
    endcase
  endtask

  // Drain the pipe before touching registers.
  task automatic settle();
    start_i <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 2) @(posedge clk_i);
  endtask

  // Offsets carry junk above bit 31, which the block has to drop.
  task automatic load_transform(input xform_t x);
    settle();
    write_reg(REG_ROW0, x.row[0]);
    write_reg(REG_ROW1, x.row[1]);
    write_reg(REG_ROW2, x.row[2]);
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? IdxSpare1 : IdxSpare0,
                RowW'({$urandom(), $urandom()}));
    end
    write_reg(REG_TRANS_X, {16'($urandom()), x.offset[0]});
    write_reg(REG_TRANS_Y, {16'($urandom()), x.offset[1]});
    write_reg(REG_TRANS_Z, {16'($urandom()), x.offset[2]});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // -------------------------------------------------------------------------
  // Random content
  // -------------------------------------------------------------------------

  // mixes magnitudes so that both exact and saturated outputs are common
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      1: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      2: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed boxes; some have one axis turned inside out
  function automatic box_in_t rand_box();
    logic [2:0][31:0] a;
    logic [2:0][31:0] c;
    logic [31:0]      t;
    box_in_t          b;
    int               j;
    int               sel;
    for (j = 0; j < 3; j++) begin
      a[j] = rand_coord();
      c[j] = rand_coord();
      if ($signed(a[j]) > $signed(c[j])) begin
        t    = a[j];
        a[j] = c[j];
        c[j] = t;
      end
    end
    if ($urandom_range(99) < 15) begin
      sel    = $urandom_range(2);
      t      = a[sel];
      a[sel] = c[sel];
      c[sel] = t;
    end
    b.min_x = a[0];
    b.min_y = a[1];
    b.min_z = a[2];
    b.max_x = c[0];
    b.max_y = c[1];
    b.max_z = c[2];
    return b;
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0:       return 16'($urandom());
      1, 2:    return 16'($urandom_range(0, 16'h2000) - 16'h1000);  // within +-1.0
      3:       return 16'h0000;
      4:       return 16'h8000;
      default: return 16'h7fff;
    endcase
  endfunction

  function automatic xform_t rand_xform();
    xform_t x;
    int     i;
    for (i = 0; i < 3; i++) begin
      x.row[i] = {rand_coef(), rand_coef(), rand_coef()};
      case ($urandom_range(3))
        0:       x.offset[i] = $urandom();
        1:       x.offset[i] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        default: x.offset[i] = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
    end
    return x;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // No writes yet: identity matrix and zero offset must come out of reset.
  task automatic test_reset_identity();
    send_box({6{32'h0000_0000}}, 0);
    send_box({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}}, 0);
    // unordered on every axis: half-size goes negative
    send_box({{3{32'h7fff_ffff}}, {3{32'h8000_0000}}}, 0);
    // odd sums exercise the floor on negative values
    send_box({32'hffff_fffd, 32'hffff_ffff, 32'h0000_0005,
              32'h0000_0007, 32'h0000_0000, 32'h0000_0005}, 0);
  endtask

  // Coefficient -8.0 and +8.0-ish, offsets at both ends, clipping both ways.
  task automatic test_coefficient_extremes();
    xform_t x;
    x.row    = {3{48'h8000_8000_8000}};
    x.offset = '0;
    load_transform(x);
    send_box({{3{32'hffff_0000}}, {3{32'h0002_0000}}}, 0);
    send_box({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}}, 0);
    send_box({{3{32'h0003_0000}}, {3{32'hfffe_0000}}}, 0);

    x.row    = {3{48'h7fff_7fff_7fff}};
    x.offset = {32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff};
    load_transform(x);
    send_box({6{32'h0000_0000}}, 0);
    send_box({{3{32'hffff_0000}}, {3{32'h0001_0000}}}, 0);
    send_box({{3{32'h8000_0000}}, {3{32'h7fff_ffff}}}, 0);

    // identity with offsets at the rails: a one-lsb nudge tips into saturation
    x.row    = {48'h1000_0000_0000, 48'h0000_1000_0000, 48'h0000_0000_1000};
    x.offset = {32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000};
    load_transform(x);
    send_box({6{32'h0000_0001}}, 0);
    send_box({6{32'hffff_ffff}}, 0);
  endtask

  // Spare indexes and junk upper data bits must leave the transform alone.
  task automatic test_register_decode();
    load_transform(rand_xform());
    write_reg(IdxSpare0, RowW'({$urandom(), $urandom()}));
    write_reg(IdxSpare1, RowW'({$urandom(), $urandom()}));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    repeat (3) send_box(rand_box(), 0);
  endtask

  // Random boxes, a fresh transform every few dozen transactions.
  task automatic test_random_stream(input int count, input int idle_pct);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) load_transform(rand_xform());
      send_box(rand_box(), idle_pct);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------

  initial begin
    int guard;
    mismatch_count = 0;
    cur_xform.row    = {48'h1000_0000_0000, 48'h0000_1000_0000, 48'h0000_0000_1000};
    cur_xform.offset = '0;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    box_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_identity();
    test_coefficient_extremes();
    test_register_decode();
    test_random_stream(120, 0);
    test_random_stream(110, 67);
    test_random_stream(110, 21);
    test_random_stream(110, 0);

    start_i <= 1'b0;
    guard = 0;
    while (boxes_due.size() != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (PipeDepth + 4) @(posedge clk_i);
    if (boxes_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", boxes_due.size()));
    end

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
